// ----- hdl/ecpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ecpa_pkg
// Types, codes and microprogram of the affine point adder.
// ----------------------------------------------------------------------------
package ecpa_pkg;

   localparam int DATA_W    = 16;
   localparam int SRC_W     = 5;
   localparam int PC_W      = 6;
   localparam int REG_N     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [DATA_W-1:0] MOD_RESET = DATA_W'(17);

   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OFF1 = 2'd1;
   localparam logic [1:0] ST_OFF2 = 2'd2;

   // scratch registers (0..15) and special operand sources
   localparam logic [SRC_W-1:0] S_A    = 5'd0;
   localparam logic [SRC_W-1:0] S_B    = 5'd1;
   localparam logic [SRC_W-1:0] S_X1   = 5'd2;
   localparam logic [SRC_W-1:0] S_Y1   = 5'd3;
   localparam logic [SRC_W-1:0] S_X2   = 5'd4;
   localparam logic [SRC_W-1:0] S_Y2   = 5'd5;
   localparam logic [SRC_W-1:0] S_L    = 5'd6;
   localparam logic [SRC_W-1:0] S_R    = 5'd7;
   localparam logic [SRC_W-1:0] S_T    = 5'd8;
   localparam logic [SRC_W-1:0] S_S    = 5'd9;
   localparam logic [SRC_W-1:0] S_U    = 5'd10;
   localparam logic [SRC_W-1:0] S_R0   = 5'd11;
   localparam logic [SRC_W-1:0] S_R1   = 5'd12;
   localparam logic [SRC_W-1:0] S_T0   = 5'd13;
   localparam logic [SRC_W-1:0] S_T1   = 5'd14;
   localparam logic [SRC_W-1:0] S_X3   = 5'd15;
   localparam logic [SRC_W-1:0] S_CA   = 5'd16;
   localparam logic [SRC_W-1:0] S_CB   = 5'd17;
   localparam logic [SRC_W-1:0] S_IX1  = 5'd18;
   localparam logic [SRC_W-1:0] S_IY1  = 5'd19;
   localparam logic [SRC_W-1:0] S_IX2  = 5'd20;
   localparam logic [SRC_W-1:0] S_IY2  = 5'd21;
   localparam logic [SRC_W-1:0] S_Q    = 5'd22;
   localparam logic [SRC_W-1:0] S_ZERO = 5'd23;
   localparam logic [SRC_W-1:0] S_ONE  = 5'd24;
   localparam logic [SRC_W-1:0] S_TRE  = 5'd25;
   localparam logic [SRC_W-1:0] S_M    = 5'd26;

   typedef enum logic [3:0] {
      OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
      OP_BEQ, OP_BNE, OP_BO1, OP_BO2, OP_JMP,
      OP_OUTP, OP_OUTO, OP_ERR1, OP_ERR2
   } uop_type;

   typedef struct packed {
      logic [DATA_W-1:0] x1;
      logic [DATA_W-1:0] y1;
      logic              first_is_infinity;
      logic [DATA_W-1:0] x2;
      logic [DATA_W-1:0] y2;
      logic              second_is_infinity;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] x3;
      logic [DATA_W-1:0] y3;
      logic              sum_is_infinity;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      uop_type          op;
      logic [SRC_W-1:0] dst;
      logic [SRC_W-1:0] src_a;
      logic [SRC_W-1:0] src_b;
      logic [PC_W-1:0]  tgt;
   } uinstr_type;

   typedef struct packed {
      logic              start;
      uop_type           op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] quot;
   } alu_rsp_type;

   function automatic uinstr_type ui(uop_type op, logic [SRC_W-1:0] d,
                                     logic [SRC_W-1:0] a, logic [SRC_W-1:0] b,
                                     logic [PC_W-1:0] t);
      uinstr_type u;
      u.op    = op;
      u.dst   = d;
      u.src_a = a;
      u.src_b = b;
      u.tgt   = t;
      return u;
   endfunction

   // microprogram: reduce, curve checks, special cases, slope, inverse, sum
   function automatic uinstr_type ucode(logic [PC_W-1:0] pc);
      uinstr_type u;
      u = ui(OP_OUTO, S_ZERO, S_ZERO, S_ZERO, 6'd0);
      unique case (pc)
         6'd0:  u = ui(OP_DIV, S_A,  S_CA,  S_M,    6'd0);
         6'd1:  u = ui(OP_DIV, S_B,  S_CB,  S_M,    6'd0);
         6'd2:  u = ui(OP_DIV, S_X1, S_IX1, S_M,    6'd0);
         6'd3:  u = ui(OP_DIV, S_Y1, S_IY1, S_M,    6'd0);
         6'd4:  u = ui(OP_DIV, S_X2, S_IX2, S_M,    6'd0);
         6'd5:  u = ui(OP_DIV, S_Y2, S_IY2, S_M,    6'd0);
         6'd6:  u = ui(OP_BO1, S_ZERO, S_ZERO, S_ZERO, 6'd14);
         6'd7:  u = ui(OP_MUL, S_L,  S_Y1,  S_Y1,   6'd0);
         6'd8:  u = ui(OP_MUL, S_R,  S_X1,  S_X1,   6'd0);
         6'd9:  u = ui(OP_MUL, S_R,  S_R,   S_X1,   6'd0);
         6'd10: u = ui(OP_MUL, S_T,  S_A,   S_X1,   6'd0);
         6'd11: u = ui(OP_ADD, S_R,  S_R,   S_T,    6'd0);
         6'd12: u = ui(OP_ADD, S_R,  S_R,   S_B,    6'd0);
         6'd13: u = ui(OP_BNE, S_ZERO, S_L, S_R,    6'd61);
         6'd14: u = ui(OP_BO2, S_ZERO, S_ZERO, S_ZERO, 6'd22);
         6'd15: u = ui(OP_MUL, S_L,  S_Y2,  S_Y2,   6'd0);
         6'd16: u = ui(OP_MUL, S_R,  S_X2,  S_X2,   6'd0);
         6'd17: u = ui(OP_MUL, S_R,  S_R,   S_X2,   6'd0);
         6'd18: u = ui(OP_MUL, S_T,  S_A,   S_X2,   6'd0);
         6'd19: u = ui(OP_ADD, S_R,  S_R,   S_T,    6'd0);
         6'd20: u = ui(OP_ADD, S_R,  S_R,   S_B,    6'd0);
         6'd21: u = ui(OP_BNE, S_ZERO, S_L, S_R,    6'd62);
         6'd22: u = ui(OP_BO1, S_ZERO, S_ZERO, S_ZERO, 6'd57);
         6'd23: u = ui(OP_BO2, S_ZERO, S_ZERO, S_ZERO, 6'd59);
         6'd24: u = ui(OP_BNE, S_ZERO, S_X1, S_X2,  6'd32);
         6'd25: u = ui(OP_BNE, S_ZERO, S_Y1, S_Y2,  6'd60);
         // tangent
         6'd26: u = ui(OP_MUL, S_L,  S_X1,  S_X1,   6'd0);
         6'd27: u = ui(OP_DIV, S_T,  S_TRE, S_M,    6'd0);
         6'd28: u = ui(OP_MUL, S_L,  S_T,   S_L,    6'd0);
         6'd29: u = ui(OP_ADD, S_L,  S_L,   S_A,    6'd0);
         6'd30: u = ui(OP_ADD, S_U,  S_Y1,  S_Y1,   6'd0);
         6'd31: u = ui(OP_JMP, S_ZERO, S_ZERO, S_ZERO, 6'd34);
         // secant
         6'd32: u = ui(OP_SUB, S_L,  S_Y2,  S_Y1,   6'd0);
         6'd33: u = ui(OP_SUB, S_U,  S_X2,  S_X1,   6'd0);
         // extended euclid on the denominator
         6'd34: u = ui(OP_MOV, S_R0, S_M,    S_ZERO, 6'd0);
         6'd35: u = ui(OP_MOV, S_R1, S_U,    S_ZERO, 6'd0);
         6'd36: u = ui(OP_MOV, S_T0, S_ZERO, S_ZERO, 6'd0);
         6'd37: u = ui(OP_MOV, S_T1, S_ONE,  S_ZERO, 6'd0);
         6'd38: u = ui(OP_BEQ, S_ZERO, S_R1, S_ZERO, 6'd48);
         6'd39: u = ui(OP_DIV, S_T,  S_R0,  S_R1,   6'd0);
         6'd40: u = ui(OP_MOV, S_R0, S_R1,  S_ZERO, 6'd0);
         6'd41: u = ui(OP_MOV, S_R1, S_T,   S_ZERO, 6'd0);
         6'd42: u = ui(OP_DIV, S_S,  S_Q,   S_M,    6'd0);
         6'd43: u = ui(OP_MUL, S_S,  S_S,   S_T1,   6'd0);
         6'd44: u = ui(OP_SUB, S_S,  S_T0,  S_S,    6'd0);
         6'd45: u = ui(OP_MOV, S_T0, S_T1,  S_ZERO, 6'd0);
         6'd46: u = ui(OP_MOV, S_T1, S_S,   S_ZERO, 6'd0);
         6'd47: u = ui(OP_JMP, S_ZERO, S_ZERO, S_ZERO, 6'd38);
         6'd48: u = ui(OP_BNE, S_ZERO, S_R0, S_ONE, 6'd60);
         // slope and sum
         6'd49: u = ui(OP_MUL, S_S,  S_L,   S_T0,   6'd0);
         6'd50: u = ui(OP_MUL, S_T,  S_S,   S_S,    6'd0);
         6'd51: u = ui(OP_SUB, S_T,  S_T,   S_X1,   6'd0);
         6'd52: u = ui(OP_SUB, S_X3, S_T,   S_X2,   6'd0);
         6'd53: u = ui(OP_SUB, S_T,  S_X1,  S_X3,   6'd0);
         6'd54: u = ui(OP_MUL, S_T,  S_S,   S_T,    6'd0);
         6'd55: u = ui(OP_SUB, S_T,  S_T,   S_Y1,   6'd0);
         6'd56: u = ui(OP_OUTP, S_ZERO, S_X3, S_T,  6'd0);
         6'd57: u = ui(OP_BO2, S_ZERO, S_ZERO, S_ZERO, 6'd60);
         6'd58: u = ui(OP_OUTP, S_ZERO, S_X2, S_Y2, 6'd0);
         6'd59: u = ui(OP_OUTP, S_ZERO, S_X1, S_Y1, 6'd0);
         6'd60: u = ui(OP_OUTO, S_ZERO, S_ZERO, S_ZERO, 6'd0);
         6'd61: u = ui(OP_ERR1, S_ZERO, S_ZERO, S_ZERO, 6'd0);
         6'd62: u = ui(OP_ERR2, S_ZERO, S_ZERO, S_ZERO, 6'd0);
         default: u = ui(OP_OUTO, S_ZERO, S_ZERO, S_ZERO, 6'd0);
      endcase
      return u;
   endfunction

endpackage

// ----- hdl/ecpa_ram.sv -----
// ----------------------------------------------------------------------------
// ecpa_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ecpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hdl/ecpa_alu.sv -----
// ----------------------------------------------------------------------------
// ecpa_alu
// Shared modular unit: add, subtract, move, bit-serial multiply and divide.
// ----------------------------------------------------------------------------
module ecpa_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  ecpa_pkg::alu_req_type         alu_req,
   input  logic [ecpa_pkg::DATA_W-1:0]   modulus,
   output ecpa_pkg::alu_rsp_type         alu_rsp
);
   import ecpa_pkg::*;

   localparam int CNT_W = $clog2(DATA_W + 1);

   typedef enum logic [2:0] {
      AL_IDLE = 3'b001,
      AL_MUL  = 3'b010,
      AL_DIV  = 3'b100
   } alu_state_type;

   alu_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] sh_ff, sh_in;
   logic [DATA_W-1:0] opd_ff, opd_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              done_ff, done_in;

   logic [DATA_W-1:0] mul_step;
   logic [DATA_W:0]   div_r;
   logic              div_ge;
   logic [DATA_W:0]   div_rem;

   function automatic logic [DATA_W-1:0] add_m(logic [DATA_W-1:0] u, logic [DATA_W-1:0] v,
                                               logic [DATA_W-1:0] m);
      logic [DATA_W:0] s;
      s = {1'b0, u} + {1'b0, v};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] sub_m(logic [DATA_W-1:0] u, logic [DATA_W-1:0] v,
                                               logic [DATA_W-1:0] m);
      logic [DATA_W-1:0] d;
      d = u - v;
      if (u < v) begin
         d = d + m;
      end
      return d;
   endfunction

   always_comb begin
      mul_step = add_m(acc_ff, acc_ff, modulus);
      if (sh_ff[DATA_W-1]) begin
         mul_step = add_m(mul_step, opd_ff, modulus);
      end
      // restoring division, one quotient bit per cycle
      div_r   = {acc_ff, sh_ff[DATA_W-1]};
      div_ge  = div_r >= {1'b0, opd_ff};
      div_rem = div_ge ? div_r - {1'b0, opd_ff} : div_r;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      opd_in   = opd_ff;
      res_in   = res_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         AL_IDLE: begin
            if (alu_req.start) begin
               case (alu_req.op)
                  OP_MUL: begin
                     acc_in   = '0;
                     opd_in   = alu_req.a;
                     sh_in    = alu_req.b;
                     cnt_in   = CNT_W'(DATA_W);
                     state_in = AL_MUL;
                  end
                  OP_DIV: begin
                     acc_in   = '0;
                     sh_in    = alu_req.a;
                     opd_in   = alu_req.b;
                     cnt_in   = CNT_W'(DATA_W);
                     state_in = AL_DIV;
                  end
                  OP_ADD: begin
                     res_in  = add_m(alu_req.a, alu_req.b, modulus);
                     done_in = 1'b1;
                  end
                  OP_SUB: begin
                     res_in  = sub_m(alu_req.a, alu_req.b, modulus);
                     done_in = 1'b1;
                  end
                  default: begin
                     res_in  = alu_req.a;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         AL_MUL: begin
            acc_in = mul_step;
            sh_in  = {sh_ff[DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               res_in   = mul_step;
               done_in  = 1'b1;
               state_in = AL_IDLE;
            end
         end
         AL_DIV: begin
            acc_in = div_rem[DATA_W-1:0];
            sh_in  = {sh_ff[DATA_W-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               res_in   = div_rem[DATA_W-1:0];
               done_in  = 1'b1;
               state_in = AL_IDLE;
            end
         end
         default: begin
            state_in = AL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      opd_ff <= opd_in;
      res_ff <= res_in;
   end

   assign alu_rsp.done = done_ff;
   assign alu_rsp.res  = res_ff;
   assign alu_rsp.quot = sh_ff;

endmodule

// ----- hdl/ec_affine_point_add_mod_p_core.sv -----
// ----------------------------------------------------------------------------
// ec_affine_point_add_mod_p_core
// Affine point addition on y^2 = x^3 + ax + b over a prime field.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  writes curve_a (0), curve_b (1) and modulus (2); other indexes are
//          dropped. Write only while no item is in flight.
//   req_*  takes one item (two points with infinity flags) when req_valid is
//          high and req_stall low. req_stall stays high from acceptance until
//          the result item has been taken.
//   rsp_*  holds one result item until a cycle with rsp_stall low.
// Operation: a microprogram drives one shared modular unit. Each step goes
// through a scratch RAM read state and an issue state; add, subtract, move
// and the bit-serial multiply and divide then wait for the unit, branches
// do not. Reductions and curve checks run first, then special cases and
// errors; a full add or double also runs the euclid inversion, up to about
// 24 rounds for a 16-bit modulus. One item at a time.
// Reset: clears the sequencer, sets a = b = 0 and modulus = 17.
// A stalled receiver holds the result and the block takes no new item.
// ----------------------------------------------------------------------------
module ec_affine_point_add_mod_p_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ecpa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ecpa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ecpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ecpa_pkg::DATA_W-1:0]         csr_wdata
);
   import ecpa_pkg::*;

   typedef enum logic [4:0] {
      SQ_IDLE  = 5'b00001,
      SQ_READ  = 5'b00010,
      SQ_ISSUE = 5'b00100,
      SQ_WAIT  = 5'b01000,
      SQ_OUT   = 5'b10000
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   req_type           item_ff, item_in;
   rsp_type           out_ff, out_in;
   logic [DATA_W-1:0] quot_ff, quot_in;
   logic [DATA_W-1:0] curve_a_ff;
   logic [DATA_W-1:0] curve_b_ff;
   logic [DATA_W-1:0] modulus_ff;

   uinstr_type        cur;
   logic [DATA_W-1:0] ram_a, ram_b;
   logic [DATA_W-1:0] opa, opb;
   logic              ram_we;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   assign cur = ucode(pc_ff);

   ecpa_ram #(.WIDTH(DATA_W), .DEPTH(REG_N)) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (cur.dst[3:0]),
      .wr_data   (alu_rsp.res),
      .rd_addr_a (cur.src_a[3:0]),
      .rd_data_a (ram_a),
      .rd_addr_b (cur.src_b[3:0]),
      .rd_data_b (ram_b)
   );

   ecpa_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .modulus (modulus_ff),
      .alu_rsp (alu_rsp)
   );

   function automatic logic [DATA_W-1:0] pick(logic [SRC_W-1:0] sel, logic [DATA_W-1:0] ram,
                                              req_type it, logic [DATA_W-1:0] ca,
                                              logic [DATA_W-1:0] cb, logic [DATA_W-1:0] m,
                                              logic [DATA_W-1:0] q);
      logic [DATA_W-1:0] v;
      case (sel)
         S_CA:    v = ca;
         S_CB:    v = cb;
         S_IX1:   v = it.x1;
         S_IY1:   v = it.y1;
         S_IX2:   v = it.x2;
         S_IY2:   v = it.y2;
         S_Q:     v = q;
         S_ZERO:  v = '0;
         S_ONE:   v = DATA_W'(1);
         S_TRE:   v = DATA_W'(3);
         S_M:     v = m;
         default: v = ram;
      endcase
      return v;
   endfunction

   assign opa = pick(cur.src_a, ram_a, item_ff, curve_a_ff, curve_b_ff, modulus_ff, quot_ff);
   assign opb = pick(cur.src_b, ram_b, item_ff, curve_a_ff, curve_b_ff, modulus_ff, quot_ff);

   always_comb begin
      alu_req.start = 1'b0;
      alu_req.op    = cur.op;
      alu_req.a     = opa;
      alu_req.b     = opb;
      ram_we        = (state_ff == SQ_WAIT) && alu_rsp.done;

      state_in = state_ff;
      pc_in    = pc_ff;
      item_in  = item_ff;
      out_in   = out_ff;
      quot_in  = quot_ff;

      unique case (state_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               pc_in   = '0;
               if (modulus_ff < DATA_W'(2)) begin
                  out_in   = '{x3: '0, y3: '0, sum_is_infinity: 1'b1, status: ST_OK};
                  state_in = SQ_OUT;
               end else begin
                  state_in = SQ_READ;
               end
            end
         end
         SQ_READ: begin
            state_in = SQ_ISSUE;
         end
         SQ_ISSUE: begin
            state_in = SQ_READ;
            pc_in    = pc_ff + PC_W'(1);
            unique case (cur.op) inside
               OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  alu_req.start = 1'b1;
                  pc_in         = pc_ff;
                  state_in      = SQ_WAIT;
               end
               OP_BEQ: begin
                  if (opa == opb) pc_in = cur.tgt;
               end
               OP_BNE: begin
                  if (opa != opb) pc_in = cur.tgt;
               end
               OP_BO1: begin
                  if (item_ff.first_is_infinity) pc_in = cur.tgt;
               end
               OP_BO2: begin
                  if (item_ff.second_is_infinity) pc_in = cur.tgt;
               end
               OP_JMP: begin
                  pc_in = cur.tgt;
               end
               OP_OUTP: begin
                  out_in   = '{x3: opa, y3: opb, sum_is_infinity: 1'b0, status: ST_OK};
                  state_in = SQ_OUT;
               end
               OP_ERR1: begin
                  out_in   = '{x3: '0, y3: '0, sum_is_infinity: 1'b0, status: ST_OFF1};
                  state_in = SQ_OUT;
               end
               OP_ERR2: begin
                  out_in   = '{x3: '0, y3: '0, sum_is_infinity: 1'b0, status: ST_OFF2};
                  state_in = SQ_OUT;
               end
               default: begin
                  out_in   = '{x3: '0, y3: '0, sum_is_infinity: 1'b1, status: ST_OK};
                  state_in = SQ_OUT;
               end
            endcase
         end
         SQ_WAIT: begin
            if (alu_rsp.done) begin
               if (cur.op == OP_DIV) quot_in = alu_rsp.quot;
               pc_in    = pc_ff + PC_W'(1);
               state_in = SQ_READ;
            end
         end
         SQ_OUT: begin
            if (!rsp_stall) state_in = SQ_IDLE;
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff   <= pc_in;
      item_ff <= item_in;
      out_ff  <= out_in;
      quot_ff <= quot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_a_ff <= '0;
         curve_b_ff <= '0;
         modulus_ff <= MOD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CURVE_A: curve_a_ff <= csr_wdata;
            CSR_CURVE_B: curve_b_ff <= csr_wdata;
            CSR_MODULUS: modulus_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != SQ_IDLE);
   assign rsp_valid = (state_ff == SQ_OUT);
   assign rsp_data  = out_ff;

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while a result is pending");

   a_error_clears_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (!rsp_data.sum_is_infinity && rsp_data.x3 == '0 && rsp_data.y3 == '0))
      else $error("error result carries a point");

   a_alu_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> (state_ff == SQ_WAIT))
      else $error("alu finished outside of wait");

endmodule
